/* hdl/lbph_pkg.sv */
// Shared constants, types and the uniform-pattern bin table of the LBP histogram unit.
`default_nettype none
package lbph_pkg;

	localparam int MAX_PATCH_SIDE_DEFAULT = 64;
	localparam int CFG_W = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int PIXEL_W = 8;
	localparam int BIN_W = 6;
	localparam int COUNT_W = 12;
	localparam int NUM_BINS = 59;
	localparam int SIDE_MIN = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH) + 1;
	localparam int OCNT_W = $clog2(OUT_DEPTH) + 1;

	localparam logic [CFG_W-1:0] SIDE_RESET = 7'd18;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [CFG_INDEX_W-1:0] CFG_PATCH_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATCH_HEIGHT = 1'b1;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic inc;
		logic eop;
	} lbph_item_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [COUNT_W-1:0] count;
		logic last;
	} lbph_result_t;

	localparam int NU = 58;

	localparam int UNIFORM_ROM [256] = '{
		 0, 1, 2, 3, 4,NU, 5, 6, 7,NU,NU,NU, 8,NU, 9,10,
		11,NU,NU,NU,NU,NU,NU,NU,12,NU,NU,NU,13,NU,14,15,
		16,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,
		17,NU,NU,NU,NU,NU,NU,NU,18,NU,NU,NU,19,NU,20,21,
		22,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,
		NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,
		23,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,
		24,NU,NU,NU,NU,NU,NU,NU,25,NU,NU,NU,26,NU,27,28,
		29,30,NU,31,NU,NU,NU,32,NU,NU,NU,NU,NU,NU,NU,33,
		NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,34,
		NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,
		NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,35,
		36,37,NU,38,NU,NU,NU,39,NU,NU,NU,NU,NU,NU,NU,40,
		NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,NU,41,
		42,43,NU,44,NU,NU,NU,45,NU,NU,NU,NU,NU,NU,NU,46,
		47,48,NU,49,NU,NU,NU,50,51,52,NU,53,54,55,56,57
	};

	function automatic logic [BIN_W-1:0] uniform_bin(input logic [7:0] code);
		return BIN_W'(UNIFORM_ROM[code]);
	endfunction

endpackage
`default_nettype wire

/* hdl/lbph_queue.sv */
// Small register FIFO used between the front and back and at the result side.
`default_nettype none
module lbph_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic [$clog2(DEPTH):0] count
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign pop_data = entry_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* hdl/lbph_front.sv */
// Front end: patch configuration, pixel position tracking, line stores, window and bin lookup.
`default_nettype none
module lbph_front import lbph_pkg::*; #(
	parameter int MAX_PATCH_SIDE = MAX_PATCH_SIDE_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic push,
	input  wire logic [PIXEL_W-1:0] pixel,
	output logic full,
	input  wire logic [QCNT_W-1:0] q_count,
	output logic q_push,
	output lbph_item_t q_item
);

	localparam int PW = $clog2(MAX_PATCH_SIDE);
	localparam int SW = $clog2(MAX_PATCH_SIDE + 1);
	localparam int CW = (SW > CFG_W) ? SW : CFG_W;

	function automatic logic [CW-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext < CW'(SIDE_MIN))
			return CW'(SIDE_MIN);
		else if (ext > CW'(MAX_PATCH_SIDE))
			return CW'(MAX_PATCH_SIDE);
		else
			return ext;
	endfunction

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [PW-1:0] col_q;
	logic [PW-1:0] row_q;

	logic [PIXEL_W-1:0] upper_mem [MAX_PATCH_SIDE];
	logic [PIXEL_W-1:0] middle_mem [MAX_PATCH_SIDE];

	logic s1_valid;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [PW-1:0] col_s1;
	logic inner_s1;
	logic eop_s1;
	logic [PIXEL_W-1:0] up_s1;
	logic [PIXEL_W-1:0] mid_s1;

	logic [PIXEL_W-1:0] win_q [6];

	logic [CW-1:0] w_eff, h_eff;
	logic [CW-1:0] c0, r0, c1, r1;
	logic inner, eop, accept;
	logic [PIXEL_W-1:0] ctr;
	logic [PIXEL_W-1:0] nb [8];
	logic [7:0] code;

	always_comb begin
		w_eff = clamp_side(width_q);
		h_eff = clamp_side(height_q);
		if (CW'(col_q) >= w_eff) begin
			c0 = '0;
			r0 = CW'(row_q) + CW'(1);
		end else begin
			c0 = CW'(col_q);
			r0 = CW'(row_q);
		end
		if (r0 >= h_eff)
			r0 = h_eff - CW'(1);
		inner = (r0 >= CW'(2)) && (c0 >= CW'(2));
		c1 = c0 + CW'(1);
		r1 = r0;
		eop = 1'b0;
		if (c1 >= w_eff) begin
			c1 = '0;
			r1 = r0 + CW'(1);
			if (r1 >= h_eff) begin
				eop = 1'b1;
				r1 = '0;
			end
		end
	end

	assign full = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid)) >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	// neighbors: up, up-left, left, down-left, down, down-right, right, up-right
	always_comb begin
		ctr = win_q[1];
		nb[0] = win_q[0];
		nb[1] = win_q[3];
		nb[2] = win_q[4];
		nb[3] = win_q[5];
		nb[4] = win_q[2];
		nb[5] = pixel_s1;
		nb[6] = mid_s1;
		nb[7] = up_s1;
		for (int k = 0; k < 8; k++)
			code[k] = (ctr >= nb[k]);
	end

	assign q_push = s1_valid;
	assign q_item.bin = uniform_bin(code);
	assign q_item.inc = inner_s1;
	assign q_item.eop = eop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIDE_RESET;
			height_q <= SIDE_RESET;
			col_q <= '0;
			row_q <= '0;
			s1_valid <= 1'b0;
			for (int k = 0; k < 6; k++)
				win_q[k] <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_PATCH_WIDTH: width_q <= cfg_data;
					CFG_PATCH_HEIGHT: height_q <= cfg_data;
				endcase
			end
			if (accept) begin
				col_q <= c1[PW-1:0];
				row_q <= r1[PW-1:0];
			end
			s1_valid <= accept;
			if (s1_valid) begin
				win_q[3] <= win_q[0];
				win_q[4] <= win_q[1];
				win_q[5] <= win_q[2];
				win_q[0] <= up_s1;
				win_q[1] <= mid_s1;
				win_q[2] <= pixel_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			upper_mem[col_s1] <= mid_s1;
			middle_mem[col_s1] <= pixel_s1;
		end
		if (accept) begin
			up_s1 <= upper_mem[c0[PW-1:0]];
			mid_s1 <= middle_mem[c0[PW-1:0]];
			pixel_s1 <= pixel;
			col_s1 <= c0[PW-1:0];
			inner_s1 <= inner;
			eop_s1 <= eop;
		end
	end

endmodule
`default_nettype wire

/* hdl/lbph_back.sv */
// Back end: bin counter memory with read-modify-write, histogram dump and result queue.
`default_nettype none
module lbph_back import lbph_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [QCNT_W-1:0] q_count,
	input  wire lbph_item_t q_item,
	output logic q_pop,
	output logic [BIN_W-1:0] bin,
	output logic [COUNT_W-1:0] bin_count,
	output logic last_bin,
	output logic empty,
	input  wire logic pop
);

	typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_DUMP} state_t;

	state_t state_q;
	logic [NUM_BINS-1:0] valid_q;
	logic [COUNT_W-1:0] cnt_mem [NUM_BINS];
	logic [COUNT_W-1:0] cnt_rd_s1;

	logic inc_valid_s1;
	logic [BIN_W-1:0] inc_bin_s1;
	logic fwd_valid_s2;
	logic [BIN_W-1:0] fwd_bin_s2;
	logic [COUNT_W-1:0] fwd_count_s2;

	logic [BIN_W-1:0] dump_k_q;
	logic dump_valid_s1;
	logic [BIN_W-1:0] dump_bin_s1;
	logic dump_last_s1;
	logic dump_hit_s1;

	logic dump_issue;
	logic [BIN_W-1:0] rd_addr;
	logic [COUNT_W-1:0] old_count, new_count;
	logic [OCNT_W-1:0] out_count;
	lbph_result_t out_data, head;

	assign q_pop = (state_q == ST_RUN) && (q_count != '0);
	assign dump_issue = (state_q == ST_DUMP) &&
		(((OCNT_W+1)'(out_count) + (OCNT_W+1)'(dump_valid_s1)) < (OCNT_W+1)'(OUT_DEPTH));
	assign rd_addr = (state_q == ST_DUMP) ? dump_k_q : q_item.bin;

	always_comb begin
		if (fwd_valid_s2 && (fwd_bin_s2 == inc_bin_s1))
			old_count = fwd_count_s2;
		else if (valid_q[inc_bin_s1])
			old_count = cnt_rd_s1;
		else
			old_count = '0;
		new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			valid_q <= '0;
			inc_valid_s1 <= 1'b0;
			inc_bin_s1 <= '0;
			fwd_valid_s2 <= 1'b0;
			fwd_bin_s2 <= '0;
			fwd_count_s2 <= '0;
			dump_k_q <= '0;
			dump_valid_s1 <= 1'b0;
			dump_bin_s1 <= '0;
			dump_last_s1 <= 1'b0;
			dump_hit_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (q_pop && q_item.eop)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					dump_k_q <= '0;
					state_q <= ST_DUMP;
				end
				ST_DUMP: begin
					if (dump_issue) begin
						dump_k_q <= dump_k_q + BIN_W'(1);
						if (dump_k_q == BIN_W'(NUM_BINS - 1))
							state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			inc_valid_s1 <= q_pop && q_item.inc;
			inc_bin_s1 <= q_item.bin;
			fwd_valid_s2 <= inc_valid_s1;
			fwd_bin_s2 <= inc_bin_s1;
			fwd_count_s2 <= new_count;

			if (inc_valid_s1)
				valid_q[inc_bin_s1] <= 1'b1;
			if (dump_issue)
				valid_q[dump_k_q] <= 1'b0;

			dump_valid_s1 <= dump_issue;
			dump_bin_s1 <= dump_k_q;
			dump_last_s1 <= (dump_k_q == BIN_W'(NUM_BINS - 1));
			dump_hit_s1 <= valid_q[dump_k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (inc_valid_s1)
			cnt_mem[inc_bin_s1] <= new_count;
		if (q_pop || dump_issue)
			cnt_rd_s1 <= cnt_mem[rd_addr];
	end

	assign out_data.bin = dump_bin_s1;
	assign out_data.count = dump_hit_s1 ? cnt_rd_s1 : '0;
	assign out_data.last = dump_last_s1;

	lbph_queue #(
		.WIDTH($bits(lbph_result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(dump_valid_s1),
		.push_data(out_data),
		.pop(pop && !empty),
		.pop_data(head),
		.count(out_count)
	);

	assign empty = (out_count == '0);
	assign bin = head.bin;
	assign bin_count = head.count;
	assign last_bin = head.last;

endmodule
`default_nettype wire

/* hdl/uniform_lbp_patch_histogram_unit.sv */
// Top level of the uniform LBP patch histogram unit.
// Pixels of a patch are pushed in raster order and the unit takes one pixel per
// cycle within a patch while full is low; each pixel passes the line-store read
// stage and one lookup of the bin table, then one counter read-modify-write in the
// back end. After the last pixel of a patch the 59 bin counts leave in bin order,
// one per cycle as they are popped, with last_bin on bin 58; the dump of the
// counter memory is one handover state and 59 reads, during which counting of the
// next patch waits and the front accepts pixels only until its 4-entry queue
// fills. The counters need no clearing pass: a valid bit per bin reads an
// untouched bin as zero. patch_width and patch_height are written through
// cfg_write/cfg_index/cfg_data while the unit is idle and saturate into
// 3..MAX_PATCH_SIDE.
`default_nettype none
module uniform_lbp_patch_histogram_unit import lbph_pkg::*; #(
	parameter int MAX_PATCH_SIDE = MAX_PATCH_SIDE_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic push,
	output logic full,
	input  wire logic [PIXEL_W-1:0] pixel,
	output logic empty,
	input  wire logic pop,
	output logic [BIN_W-1:0] bin,
	output logic [COUNT_W-1:0] bin_count,
	output logic last_bin
);

	logic q_push, q_pop;
	lbph_item_t q_in, q_out;
	logic [QCNT_W-1:0] q_count;

	lbph_front #(
		.MAX_PATCH_SIDE(MAX_PATCH_SIDE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.pixel(pixel),
		.full(full),
		.q_count(q_count),
		.q_push(q_push),
		.q_item(q_in)
	);

	lbph_queue #(
		.WIDTH($bits(lbph_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.pop(q_pop),
		.pop_data(q_out),
		.count(q_count)
	);

	lbph_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_count(q_count),
		.q_item(q_out),
		.q_pop(q_pop),
		.bin(bin),
		.bin_count(bin_count),
		.last_bin(last_bin),
		.empty(empty),
		.pop(pop)
	);

endmodule
`default_nettype wire

/* bench/uniform_lbp_patch_histogram_unit_tb.sv */
// Self-checking bench for the uniform LBP patch histogram unit: patch streams against a model.
`timescale 1ns / 100ps
module uniform_lbp_patch_histogram_unit_tb;
	import lbph_pkg::*;

	localparam int SIDE_MAX = MAX_PATCH_SIDE_DEFAULT;
	localparam logic [BIN_W-1:0] NON_UNIFORM_BIN = 6'd58;
	localparam logic [BIN_W-1:0] BIN_ALL_GE = 6'd57;
	localparam logic [BIN_W-1:0] BIN_NONE_GE = 6'd0;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PIXELS = 30;
	localparam int NUM_DIRECTED = 7;

	typedef enum logic [2:0] {PAT_FLAT, PAT_CENTER, PAT_RAMP, PAT_NOISE, PAT_SPLIT} pattern_t;

	// wr: bit 0 writes the width, bit 1 the height
	typedef struct packed {
		logic [1:0] wr;
		logic [CFG_W-1:0] w_raw;
		logic [CFG_W-1:0] h_raw;
		pattern_t pat;
		logic [7:0] a;
		logic [7:0] b;
		logic typed;
		logic [BIN_W-1:0] exp_bin;
		logic [COUNT_W-1:0] exp_count;
	} patch_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [PIXEL_W-1:0] pixel = '0;
	logic empty;
	logic pop = 1'b0;
	logic [BIN_W-1:0] bin;
	logic [COUNT_W-1:0] bin_count;
	logic last_bin;

	uniform_lbp_patch_histogram_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.pixel(pixel),
		.empty(empty),
		.pop(pop),
		.bin(bin),
		.bin_count(bin_count),
		.last_bin(last_bin)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state
	logic [CFG_W-1:0] reg_w = SIDE_RESET;
	logic [CFG_W-1:0] reg_h = SIDE_RESET;
	logic [7:0] upper_row [SIDE_MAX];
	logic [7:0] middle_row [SIDE_MAX];
	logic [7:0] win [6];
	int col_pos = 0;
	int row_pos = 0;
	int unsigned hist [NUM_BINS];
	int unsigned hist_snap [NUM_BINS];
	logic [BIN_W-1:0] bin_of_code [256];

	lbph_result_t pending_bins [$];
	lbph_result_t head;
	patch_row_t directed_rows [NUM_DIRECTED];

	bit idle_on = 1'b1;
	bit typed_on = 1'b0;
	logic [BIN_W-1:0] typed_bin;
	logic [COUNT_W-1:0] typed_count;
	int fail_count = 0;
	int pixel_total = 0;
	int patch_total = 0;
	int bins_seen = 0;
	int quiet_cycles = 0;

	function automatic int side_of(input logic [CFG_W-1:0] v);
		if (v < SIDE_MIN)
			return SIDE_MIN;
		if (v > SIDE_MAX)
			return SIDE_MAX;
		return int'(v);
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_PATCH_WIDTH)
			reg_w = val;
		else
			reg_h = val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// one pixel through the window; done marks the end of a patch
	task automatic count_pixel(input logic [7:0] cur, output bit done);
		int w, h, c, r, k;
		logic [7:0] up_new, mid_new, ctr;
		logic [7:0] nb [8];
		logic [7:0] code;
		logic [BIN_W-1:0] b;
		w = side_of(reg_w);
		h = side_of(reg_h);
		c = col_pos;
		r = row_pos;
		done = 1'b0;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = h - 1;
		up_new = upper_row[c];
		mid_new = middle_row[c];
		if (r >= 2 && c >= 2) begin
			ctr = win[1];
			nb = '{win[0], win[3], win[4], win[5], win[2], cur, mid_new, up_new};
			code = '0;
			for (k = 0; k < 8; k++)
				if (ctr >= nb[k])
					code[k] = 1'b1;
			b = bin_of_code[code];
			if (hist[b] < COUNT_MAX)
				hist[b]++;
		end
		upper_row[c] = mid_new;
		middle_row[c] = cur;
		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = up_new;
		win[1] = mid_new;
		win[2] = cur;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				done = 1'b1;
				r = 0;
				for (k = 0; k < NUM_BINS; k++) begin
					hist_snap[k] = hist[k];
					hist[k] = 0;
				end
			end
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic send_pixel(input logic [7:0] p);
		int gap, k;
		bit done;
		lbph_result_t e;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		@(negedge clk);
		push <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full !== 1'b0);
		pixel_total++;
		count_pixel(p, done);
		if (done) begin
			patch_total++;
			for (k = 0; k < NUM_BINS; k++) begin
				e.bin = BIN_W'(k);
				if (typed_on)
					e.count = (BIN_W'(k) == typed_bin) ? typed_count : '0;
				else
					e.count = COUNT_W'(hist_snap[k]);
				e.last = (k == NUM_BINS - 1);
				pending_bins.insert(pending_bins.size(), e);
			end
		end
	endtask

	task automatic run_patch(input patch_row_t rw);
		int w, h, r, c;
		logic [7:0] p;
		w = side_of(reg_w);
		h = side_of(reg_h);
		typed_on = rw.typed;
		typed_bin = rw.exp_bin;
		typed_count = rw.exp_count;
		for (r = 0; r < h; r++)
			for (c = 0; c < w; c++) begin
				case (rw.pat)
					PAT_FLAT: p = rw.a;
					PAT_CENTER: p = (r > 0 && r < h - 1 && c > 0 && c < w - 1) ? rw.b : rw.a;
					PAT_RAMP: p = 8'(c * rw.a);
					PAT_NOISE: p = 8'($urandom_range(rw.a, rw.b));
					default: p = $urandom_range(0, 1) ? rw.b : rw.a;
				endcase
				send_pixel(p);
			end
	endtask

	// drain every expected bin, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int i, k, trans, idx, n, start_pixels, sel;
		logic [7:0] code;
		patch_row_t rw;
		idx = 0;
		for (i = 0; i < 256; i++) begin
			code = 8'(i);
			trans = 0;
			for (k = 0; k < 8; k++)
				if (code[k] != code[(k + 1) % 8])
					trans++;
			if (trans <= 2) begin
				bin_of_code[i] = BIN_W'(idx);
				idx++;
			end else begin
				bin_of_code[i] = NON_UNIFORM_BIN;
			end
		end
		for (i = 0; i < SIDE_MAX; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		for (i = 0; i < 6; i++)
			win[i] = '0;
		for (i = 0; i < NUM_BINS; i++)
			hist[i] = 0;

		// width left at its reset value
		directed_rows[0] = '{2'b10, 7'd0, 7'd3, PAT_FLAT, 8'd0, 8'd0, 1'b1, BIN_ALL_GE, 12'd16};
		directed_rows[1] = '{2'b11, 7'd3, 7'd3, PAT_CENTER, 8'd0, 8'd255, 1'b1, BIN_ALL_GE, 12'd1};
		directed_rows[2] = '{2'b11, 7'd3, 7'd3, PAT_CENTER, 8'd255, 8'd0, 1'b1, BIN_NONE_GE,
			12'd1};
		directed_rows[3] = '{2'b11, 7'd0, 7'd0, PAT_FLAT, 8'd255, 8'd0, 1'b1, BIN_ALL_GE, 12'd1};
		directed_rows[4] = '{2'b11, 7'd2, 7'd1, PAT_NOISE, 8'd0, 8'd255, 1'b0, 6'd0, 12'd0};
		directed_rows[5] = '{2'b11, 7'd5, 7'd4, PAT_RAMP, 8'd60, 8'd0, 1'b0, 6'd0, 12'd0};
		directed_rows[6] = '{2'b11, 7'd4, 7'd4, PAT_SPLIT, 8'd0, 8'd255, 1'b0, 6'd0, 12'd0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].wr[0])
				write_reg(CFG_PATCH_WIDTH, directed_rows[i].w_raw);
			if (directed_rows[i].wr[1])
				write_reg(CFG_PATCH_HEIGHT, directed_rows[i].h_raw);
			run_patch(directed_rows[i]);
			settle();
		end

		start_pixels = pixel_total;
		while (pixel_total - start_pixels < RANDOM_PIXELS) begin
			rw.wr = 2'b11;
			rw.typed = 1'b0;
			rw.exp_bin = '0;
			rw.exp_count = '0;
			rw.w_raw = 7'($urandom_range(3, 5));
			rw.h_raw = 7'($urandom_range(3, 5));
			sel = $urandom_range(0, 7);
			if (sel == 0)
				rw.w_raw = 7'($urandom_range(0, 2));
			else if (sel == 1)
				rw.h_raw = 7'($urandom_range(0, 2));
			write_reg(CFG_PATCH_WIDTH, rw.w_raw);
			write_reg(CFG_PATCH_HEIGHT, rw.h_raw);
			n = $urandom_range(1, 2);
			repeat (n) begin
				sel = $urandom_range(0, 5);
				rw.pat = PAT_NOISE;
				rw.a = 8'd0;
				rw.b = 8'd255;
				if (sel == 3) begin
					rw.a = 8'($urandom_range(0, 252));
					rw.b = rw.a + 8'd3;
				end else if (sel == 4) begin
					rw.pat = PAT_SPLIT;
					rw.a = 8'($urandom_range(0, 255));
					rw.b = 8'($urandom_range(0, 255));
				end else if (sel == 5) begin
					rw.pat = PAT_FLAT;
					rw.a = 8'($urandom_range(0, 255));
				end
				run_patch(rw);
			end
			settle();
		end

		// closing stretch at full rate on both sides
		idle_on = 1'b0;
		rw = '{2'b11, 7'd4, 7'd3, PAT_NOISE, 8'd0, 8'd255, 1'b0, 6'd0, 12'd0};
		write_reg(CFG_PATCH_WIDTH, rw.w_raw);
		write_reg(CFG_PATCH_HEIGHT, rw.h_raw);
		repeat (2) run_patch(rw);
		settle();

		$display("run: %0d patches, %0d pixels, %0d bin counts compared", patch_total,
			pixel_total, bins_seen);
		$display("run: reset width, small and clamped sides, flat, peak, ramp, split and noise");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// result side: bursts of stall and of steady pop
	initial begin
		int n;
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 18);
				repeat (n) begin
					@(negedge clk);
					pop <= 1'b0;
				end
			end else begin
				n = $urandom_range(1, 40);
				repeat (n) begin
					@(negedge clk);
					pop <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) begin
			bins_seen++;
			if (pending_bins.size() == 0) begin
				$error("bin transfer with nothing pending: bin %0d count %0d", bin, bin_count);
				fail_count++;
			end else begin
				head = pending_bins.pop_front();
				if (bin !== head.bin) begin
					$error("bin: expected %0d, actual %0d", head.bin, bin);
					fail_count++;
				end
				if (bin_count !== head.count) begin
					$error("bin_count: expected %0d, actual %0d", head.count, bin_count);
					fail_count++;
				end
				if (last_bin !== head.last) begin
					$error("last_bin: expected %0d, actual %0d", head.last, last_bin);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && full === 1'b0) || (pop && empty === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d bins pending", quiet_cycles,
				pending_bins.size());
			$display("status: fail");
			$finish;
		end
	end

endmodule
